FILE: rtl/core/battery_power_state_monitor_unit_assert.svh
// Assertion macros for the battery power-state monitor.
// Used by the top level only; clocked on clk_i, reset by rst_ni.
`ifndef BATTERY_POWER_STATE_MONITOR_UNIT_ASSERT_SVH
`define BATTERY_POWER_STATE_MONITOR_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define BPSM_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("bpsm assertion failed");
`define BPSM_ASSERT_IN_RESET(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("bpsm reset assertion failed");
`else
`define BPSM_ASSERT(label, prop)
`define BPSM_ASSERT_IN_RESET(label, prop)
`endif
`endif

FILE: rtl/core/bpsm_pkg.sv
// Shared types, constants and helper functions of the battery power-state monitor.
// No dependencies; used by every module of the block.
package bpsm_pkg;

  localparam int unsigned MV_W          = 13;
  localparam int unsigned TICK_W        = 32;
  localparam int unsigned STEP_W        = 4;
  localparam int unsigned LEVEL_W       = 7;
  localparam int unsigned PSTATE_W      = 2;
  localparam int unsigned LEVEL_ENTRIES = 10;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 32;
  localparam int unsigned QUEUE_DEPTH   = 2;
  localparam int unsigned QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  typedef logic [MV_W-1:0]     mv_t;
  typedef logic [TICK_W-1:0]   tick_t;
  typedef logic [STEP_W-1:0]   step_t;
  typedef logic [LEVEL_W-1:0]  level_t;
  typedef logic [PSTATE_W-1:0] pstate_t;

  localparam pstate_t ST_CHARGED  = 2'd0;
  localparam pstate_t ST_CHARGING = 2'd1;
  localparam pstate_t ST_LOW      = 2'd2;
  localparam pstate_t ST_BATTERY  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_LOW_MV        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CRIT_MV       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_TIMEOUT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CRIT_TIMEOUT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INACT_TIMEOUT = 3'd4;

  localparam mv_t   LOW_MV_RESET        = 13'd3200;
  localparam mv_t   CRIT_MV_RESET       = 13'd3000;
  localparam tick_t LOW_TIMEOUT_RESET   = 32'd5000;
  localparam tick_t CRIT_TIMEOUT_RESET  = 32'd5000;
  localparam tick_t INACT_TIMEOUT_RESET = 32'd300000;
  localparam mv_t   MIN_MV_RESET        = 13'd6000;
  localparam mv_t   MAX_MV_RESET        = 13'd0;

  localparam mv_t STEP_TABLE_MV [LEVEL_ENTRIES] = '{
    13'd3000, 13'd3780, 13'd3830, 13'd3870, 13'd3890,
    13'd3920, 13'd3960, 13'd4000, 13'd4040, 13'd4100
  };

  typedef struct packed {
    mv_t   low_mv;
    mv_t   crit_mv;
    tick_t low_timeout;
    tick_t crit_timeout;
    tick_t inact_timeout;
  } cfg_t;

  typedef struct packed {
    mv_t    mv;
    tick_t  tick;
    step_t  step;
    level_t level;
    logic   above_low;
    logic   above_crit;
    logic   power_good;
    logic   charging;
    logic   inact_over;
  } sample_t;

  typedef struct packed {
    level_t  level_percent;
    step_t   charge_step;
    mv_t     min_mv;
    mv_t     max_mv;
    pstate_t power_state;
    logic    state_changed;
    logic    can_fly;
    logic    charging_led_start;
    logic    lowbat_led_start;
    logic    shutdown_request;
  } result_t;

  function automatic step_t step_of(input mv_t mv);
    step_t s;
    s = STEP_W'(LEVEL_ENTRIES - 1);
    for (int i = LEVEL_ENTRIES - 2; i >= 0; i--) begin
      if (mv <= STEP_TABLE_MV[i]) begin
        s = STEP_W'(i);
      end
    end
    return s;
  endfunction

  function automatic level_t level_of(input step_t step);
    return LEVEL_W'({step, 3'b000}) + LEVEL_W'({step, 1'b0});
  endfunction

endpackage

FILE: rtl/core/bpsm_front.sv
// Front end: classifies one raw sample into a queue word.
// Depends on bpsm_pkg (sample_t, cfg_t, step table helpers).
module bpsm_front (
  input  bpsm_pkg::mv_t     battery_mv_i,
  input  logic              power_good_i,
  input  logic              charging_i,
  input  bpsm_pkg::tick_t   tick_now_i,
  input  bpsm_pkg::tick_t   inactivity_ticks_i,
  input  bpsm_pkg::cfg_t    cfg_i,
  output bpsm_pkg::sample_t sample_o
);

  bpsm_pkg::step_t step;

  always_comb begin
    step                = bpsm_pkg::step_of(battery_mv_i);
    sample_o.mv         = battery_mv_i;
    sample_o.tick       = tick_now_i;
    sample_o.step       = step;
    sample_o.level      = bpsm_pkg::level_of(step);
    sample_o.above_low  = battery_mv_i > cfg_i.low_mv;
    sample_o.above_crit = battery_mv_i > cfg_i.crit_mv;
    sample_o.power_good = power_good_i;
    sample_o.charging   = charging_i;
    sample_o.inact_over = inactivity_ticks_i > cfg_i.inact_timeout;
  end

endmodule

FILE: rtl/core/bpsm_queue.sv
// Short FIFO of classified samples between the front and the back end.
// Depends on bpsm_pkg (sample_t, queue depth constants).
module bpsm_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  bpsm_pkg::sample_t push_data_i,
  output logic              not_full_o,
  input  logic              pop_i,
  output logic              head_valid_o,
  output bpsm_pkg::sample_t head_o,
  output logic [bpsm_pkg::QCNT_W-1:0] count_o
);

  bpsm_pkg::sample_t                  mem_q [bpsm_pkg::QUEUE_DEPTH];
  logic [bpsm_pkg::QPTR_W-1:0]        wr_ptr_q, wr_ptr_d;
  logic [bpsm_pkg::QPTR_W-1:0]        rd_ptr_q, rd_ptr_d;
  logic [bpsm_pkg::QCNT_W-1:0]        count_q, count_d;

  assign not_full_o   = count_q != bpsm_pkg::QCNT_W'(bpsm_pkg::QUEUE_DEPTH);
  assign head_valid_o = count_q != '0;
  assign head_o       = mem_q[rd_ptr_q];
  assign count_o      = count_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == bpsm_pkg::QPTR_W'(bpsm_pkg::QUEUE_DEPTH - 1)) ? '0
                 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == bpsm_pkg::QPTR_W'(bpsm_pkg::QUEUE_DEPTH - 1)) ? '0
                 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: rtl/core/bpsm_back.sv
// Back end: running extremes, voltage stamps, power state and result register.
// Depends on bpsm_pkg (sample_t, result_t, cfg_t, state codes).
module bpsm_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  bpsm_pkg::sample_t head_i,
  output logic              pop_o,
  input  bpsm_pkg::cfg_t    cfg_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bpsm_pkg::result_t result_o
);

  bpsm_pkg::mv_t     min_q, min_d, max_q, max_d;
  bpsm_pkg::tick_t   low_stamp_q, low_stamp_d, crit_stamp_q, crit_stamp_d;
  bpsm_pkg::tick_t   low_time, crit_time;
  bpsm_pkg::pstate_t prev_q, state;
  logic              fly_q, fly_d, changed;
  logic              out_valid_q;
  bpsm_pkg::result_t res_q, res_d;

  assign pop_o       = head_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

  always_comb begin
    max_d        = (max_q < head_i.mv) ? head_i.mv : max_q;
    min_d        = (min_q > head_i.mv) ? head_i.mv : min_q;
    low_stamp_d  = head_i.above_low ? head_i.tick : low_stamp_q;
    crit_stamp_d = head_i.above_crit ? head_i.tick : crit_stamp_q;
    low_time     = head_i.tick - low_stamp_d;
    crit_time    = head_i.tick - crit_stamp_d;

    if (head_i.power_good && !head_i.charging) begin
      state = bpsm_pkg::ST_CHARGED;
    end else if (head_i.power_good && head_i.charging) begin
      state = bpsm_pkg::ST_CHARGING;
    end else if (!head_i.charging && low_time > cfg_i.low_timeout) begin
      state = bpsm_pkg::ST_LOW;
    end else begin
      state = bpsm_pkg::ST_BATTERY;
    end

    changed = state != prev_q;
    fly_d   = changed ? (state == bpsm_pkg::ST_LOW || state == bpsm_pkg::ST_BATTERY) : fly_q;

    res_d.level_percent      = head_i.level;
    res_d.charge_step        = head_i.step;
    res_d.min_mv             = min_d;
    res_d.max_mv             = max_d;
    res_d.power_state        = state;
    res_d.state_changed      = changed;
    res_d.can_fly            = fly_d;
    res_d.charging_led_start = changed && state == bpsm_pkg::ST_CHARGING;
    res_d.lowbat_led_start   = changed && state == bpsm_pkg::ST_LOW;
    res_d.shutdown_request   =
      (state == bpsm_pkg::ST_LOW && crit_time > cfg_i.crit_timeout) ||
      (state == bpsm_pkg::ST_BATTERY && head_i.inact_over);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q        <= bpsm_pkg::MIN_MV_RESET;
      max_q        <= bpsm_pkg::MAX_MV_RESET;
      low_stamp_q  <= '0;
      crit_stamp_q <= '0;
      prev_q       <= bpsm_pkg::ST_BATTERY;
      fly_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (pop_o) begin
        min_q        <= min_d;
        max_q        <= max_d;
        low_stamp_q  <= low_stamp_d;
        crit_stamp_q <= crit_stamp_d;
        prev_q       <= state;
        fly_q        <= fly_d;
        out_valid_q  <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
    end
  end

endmodule

FILE: rtl/core/battery_power_state_monitor_unit.sv
// Top level of the battery power-state monitor: config registers, front, queue, back.
// Depends on bpsm_pkg, bpsm_front, bpsm_queue, bpsm_back and the assertion header.
//
//   channel   direction  handshake                  payload
//   cfg       in         cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//   in        in         in_valid_i / in_ready_o    battery_mv_i .. inactivity_ticks_i
//   out       out        out_valid_o / out_ready_i  level_percent_o .. shutdown_request_o
//
// One sample per cycle sustained while out_ready_i stays high.
// A sample's word goes through the queue and is loaded into the result register on its pop.
// Reset clears the extremes, stamps, power state and config to their defaults.
// A stalled output fills the two-word queue, then in_ready_o drops.
// Config writes are taken every cycle.
`include "battery_power_state_monitor_unit_assert.svh"

module battery_power_state_monitor_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [bpsm_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [bpsm_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  bpsm_pkg::mv_t                      battery_mv_i,
  input  logic                               power_good_i,
  input  logic                               charging_i,
  input  bpsm_pkg::tick_t                    tick_now_i,
  input  bpsm_pkg::tick_t                    inactivity_ticks_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output bpsm_pkg::level_t                   level_percent_o,
  output bpsm_pkg::step_t                    charge_step_o,
  output bpsm_pkg::mv_t                      min_mv_o,
  output bpsm_pkg::mv_t                      max_mv_o,
  output bpsm_pkg::pstate_t                  power_state_o,
  output logic                               state_changed_o,
  output logic                               can_fly_o,
  output logic                               charging_led_start_o,
  output logic                               lowbat_led_start_o,
  output logic                               shutdown_request_o
);

  bpsm_pkg::cfg_t     cfg_q;
  bpsm_pkg::sample_t  sample, head;
  bpsm_pkg::result_t  result;
  logic               push, pop, head_valid, not_full;
  logic [bpsm_pkg::QCNT_W-1:0] q_count;
  logic               out_low, out_fly_state;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = not_full;
  assign push        = in_valid_i && not_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_mv        <= bpsm_pkg::LOW_MV_RESET;
      cfg_q.crit_mv       <= bpsm_pkg::CRIT_MV_RESET;
      cfg_q.low_timeout   <= bpsm_pkg::LOW_TIMEOUT_RESET;
      cfg_q.crit_timeout  <= bpsm_pkg::CRIT_TIMEOUT_RESET;
      cfg_q.inact_timeout <= bpsm_pkg::INACT_TIMEOUT_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bpsm_pkg::CFG_LOW_MV:        cfg_q.low_mv        <= cfg_data_i[bpsm_pkg::MV_W-1:0];
        bpsm_pkg::CFG_CRIT_MV:       cfg_q.crit_mv       <= cfg_data_i[bpsm_pkg::MV_W-1:0];
        bpsm_pkg::CFG_LOW_TIMEOUT:   cfg_q.low_timeout   <= cfg_data_i[bpsm_pkg::TICK_W-1:0];
        bpsm_pkg::CFG_CRIT_TIMEOUT:  cfg_q.crit_timeout  <= cfg_data_i[bpsm_pkg::TICK_W-1:0];
        bpsm_pkg::CFG_INACT_TIMEOUT: cfg_q.inact_timeout <= cfg_data_i[bpsm_pkg::TICK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  bpsm_front u_front (
    .battery_mv_i       (battery_mv_i),
    .power_good_i       (power_good_i),
    .charging_i         (charging_i),
    .tick_now_i         (tick_now_i),
    .inactivity_ticks_i (inactivity_ticks_i),
    .cfg_i              (cfg_q),
    .sample_o           (sample)
  );

  bpsm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (sample),
    .not_full_o   (not_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head),
    .count_o      (q_count)
  );

  bpsm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .cfg_i        (cfg_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .result_o     (result)
  );

  assign level_percent_o      = result.level_percent;
  assign charge_step_o        = result.charge_step;
  assign min_mv_o             = result.min_mv;
  assign max_mv_o             = result.max_mv;
  assign power_state_o        = result.power_state;
  assign state_changed_o      = result.state_changed;
  assign can_fly_o            = result.can_fly;
  assign charging_led_start_o = result.charging_led_start;
  assign lowbat_led_start_o   = result.lowbat_led_start;
  assign shutdown_request_o   = result.shutdown_request;

  assign out_low       = power_state_o == bpsm_pkg::ST_LOW;
  assign out_fly_state = out_low || power_state_o == bpsm_pkg::ST_BATTERY;

  `BPSM_ASSERT_IN_RESET(a_no_output_in_reset, !rst_ni |=> !out_valid_o && q_count == '0)
  `BPSM_ASSERT(a_extremes_ordered, out_valid_o |-> min_mv_o <= max_mv_o)
  `BPSM_ASSERT(a_lowbat_on_change, out_valid_o && lowbat_led_start_o |-> state_changed_o && out_low)
  `BPSM_ASSERT(a_fly_on_change, out_valid_o && state_changed_o |-> can_fly_o == out_fly_state)
  `BPSM_ASSERT(a_shutdown_states, out_valid_o && shutdown_request_o |-> out_fly_state)

endmodule

FILE: dv/tb.sv
// Testbench for battery_power_state_monitor_unit: directed, corner-config, random, stall runs.
// Predicts each report in-line and checks it field by field; depends on bpsm_pkg and the RTL.
module tb;
  import bpsm_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned FIRST_SPARE_IDX = CFG_INACT_TIMEOUT + 1;
  localparam int unsigned STEP_LIMIT_MV [LEVEL_ENTRIES] = '{
    3000, 3780, 3830, 3870, 3890, 3920, 3960, 4000, 4040, 4100
  };

  typedef struct packed {
    mv_t   mv;
    logic  power_good;
    logic  charging;
    tick_t tick;
    tick_t idle_ticks;
  } reading_t;

  typedef enum logic [1:0] {SCENE_DISCHARGE, SCENE_ON_CHARGER, SCENE_NOISE} scene_e;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]   cfg_data_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  mv_t                     battery_mv_i = '0;
  logic                    power_good_i = 1'b0;
  logic                    charging_i = 1'b0;
  tick_t                   tick_now_i = '0;
  tick_t                   inactivity_ticks_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  level_t                  level_percent_o;
  step_t                   charge_step_o;
  mv_t                     min_mv_o;
  mv_t                     max_mv_o;
  pstate_t                 power_state_o;
  logic                    state_changed_o;
  logic                    can_fly_o;
  logic                    charging_led_start_o;
  logic                    lowbat_led_start_o;
  logic                    shutdown_request_o;

  battery_power_state_monitor_unit dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor state
  cfg_t    limits = '{13'd3200, 13'd3000, 32'd5000, 32'd5000, 32'd300000};
  mv_t     seen_min_mv = 13'd6000;
  mv_t     seen_max_mv = 13'd0;
  tick_t   above_low_tick = '0;
  tick_t   above_crit_tick = '0;
  pstate_t last_state = ST_BATTERY;
  logic    fly_ok = 1'b0;
  result_t pending_reports[$];

  // stimulus state
  tick_t       tick_cursor = 32'd20000;
  int          volt_cursor = 4000;
  scene_e      scene = SCENE_NOISE;
  int          scene_left = 0;
  int          burst_left = 0;
  bit          gaps_on = 1'b1;
  bit          feeding = 1'b0;
  int          mismatches = 0;
  int unsigned cycles = 0;

  // receiver state
  int          hold_len = 0;
  int          hold_left = 0;
  logic [15:0] ready_mask = '1;
  logic [3:0]  ready_pos = '0;

  function automatic result_t forecast_report(input reading_t r);
    result_t rep;
    tick_t   low_age;
    tick_t   crit_age;
    pstate_t next;
    int      step;
    if (r.mv > seen_max_mv) seen_max_mv = r.mv;
    if (r.mv < seen_min_mv) seen_min_mv = r.mv;
    step = LEVEL_ENTRIES - 1;
    for (int i = LEVEL_ENTRIES - 1; i >= 0; i--) begin
      if (r.mv <= STEP_LIMIT_MV[i]) step = i;
    end
    if (r.mv > limits.low_mv) above_low_tick = r.tick;
    if (r.mv > limits.crit_mv) above_crit_tick = r.tick;
    low_age = r.tick - above_low_tick;
    crit_age = r.tick - above_crit_tick;
    if (r.power_good) begin
      next = r.charging ? ST_CHARGING : ST_CHARGED;
    end else if (!r.charging && low_age > limits.low_timeout) begin
      next = ST_LOW;
    end else begin
      next = ST_BATTERY;
    end
    rep = '0;
    rep.state_changed = (next != last_state);
    if (rep.state_changed) begin
      fly_ok = (next == ST_LOW) || (next == ST_BATTERY);
      rep.charging_led_start = (next == ST_CHARGING);
      rep.lowbat_led_start = (next == ST_LOW);
      last_state = next;
    end
    rep.shutdown_request = (next == ST_LOW && crit_age > limits.crit_timeout) ||
                           (next == ST_BATTERY && r.idle_ticks > limits.inact_timeout);
    rep.level_percent = level_t'(step * 10);
    rep.charge_step = step_t'(step);
    rep.min_mv = seen_min_mv;
    rep.max_mv = seen_max_mv;
    rep.power_state = next;
    rep.can_fly = fly_ok;
    return rep;
  endfunction

  function automatic tick_t pick_timeout();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return $urandom;
      3: return $urandom_range(1, 200);
      default: return $urandom_range(500, 20000);
    endcase
  endfunction

  function automatic cfg_t random_limits();
    cfg_t c;
    c.low_mv = mv_t'($urandom_range(2900, 3700));
    c.crit_mv = mv_t'($urandom_range(2700, 3400));
    if ($urandom_range(0, 7) == 0) c.low_mv = mv_t'($urandom);
    if ($urandom_range(0, 7) == 0) c.crit_mv = mv_t'($urandom);
    c.low_timeout = pick_timeout();
    c.crit_timeout = pick_timeout();
    c.inact_timeout = pick_timeout();
    return c;
  endfunction

  function automatic reading_t next_reading();
    reading_t    r;
    int          mv;
    int unsigned span;
    if (scene_left == 0) begin
      scene_left = $urandom_range(6, 30);
      scene = scene_e'($urandom_range(0, 2));
      if (scene == SCENE_DISCHARGE) volt_cursor = $urandom_range(3900, 4400);
    end
    scene_left--;
    span = (limits.low_timeout < limits.crit_timeout) ? limits.low_timeout
                                                      : limits.crit_timeout;
    if (span < 48) span = 48;
    if (span > 300000) span = 300000;
    case ($urandom_range(0, 15))
      0: tick_cursor += $urandom;
      1, 2: tick_cursor += $urandom_range(0, 2);
      default: tick_cursor += $urandom_range(0, span / 3);
    endcase
    r.tick = tick_cursor;
    case (scene)
      SCENE_DISCHARGE: begin
        volt_cursor -= $urandom_range(0, 90);
        if (volt_cursor < 2200) volt_cursor = 2200;
        mv = volt_cursor + $urandom_range(0, 30) - 15;
        r.power_good = 1'b0;
        r.charging = ($urandom_range(0, 9) == 0);
      end
      SCENE_ON_CHARGER: begin
        volt_cursor += $urandom_range(0, 40);
        if (volt_cursor > 4300) volt_cursor = 4300;
        mv = volt_cursor;
        r.power_good = 1'b1;
        r.charging = ($urandom_range(0, 4) != 0);
      end
      default: begin
        case ($urandom_range(0, 3))
          0: mv = $urandom_range(0, 8191);
          1: mv = STEP_LIMIT_MV[$urandom_range(0, LEVEL_ENTRIES - 1)] + $urandom_range(0, 2) - 1;
          2: mv = limits.low_mv + $urandom_range(0, 2) - 1;
          default: mv = limits.crit_mv + $urandom_range(0, 2) - 1;
        endcase
        r.power_good = ($urandom_range(0, 1) != 0);
        r.charging = ($urandom_range(0, 1) != 0);
      end
    endcase
    if (mv < 0) mv = 0;
    if (mv > 8191) mv = 8191;
    r.mv = mv_t'(mv);
    case ($urandom_range(0, 5))
      0: r.idle_ticks = $urandom;
      1: r.idle_ticks = $urandom_range(0, 1000);
      default: r.idle_ticks = limits.inact_timeout + $urandom_range(0, 4) - 2;
    endcase
    return r;
  endfunction

  task automatic feed_reading(input reading_t r);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if (gaps_on && $urandom_range(0, 2) != 0) begin
        if (feeding) in_valid_i <= 1'b0;
        feeding = 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    battery_mv_i <= r.mv;
    power_good_i <= r.power_good;
    charging_i <= r.charging;
    tick_now_i <= r.tick;
    inactivity_ticks_i <= r.idle_ticks;
    feeding = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    pending_reports.push_back(forecast_report(r));
  endtask

  task automatic settle_reports();
    if (feeding) in_valid_i <= 1'b0;
    feeding = 1'b0;
    do @(posedge clk_i); while (pending_reports.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic program_limits(input cfg_t c);
    logic [CFG_DATA_W-1:0] word;
    logic [CFG_IDX_W-1:0]  spare;
    spare = CFG_IDX_W'($urandom_range(FIRST_SPARE_IDX, (1 << CFG_IDX_W) - 1));
    write_reg(spare, $urandom);
    word = $urandom;
    word[MV_W-1:0] = c.low_mv;
    write_reg(CFG_LOW_MV, word);
    word = $urandom;
    word[MV_W-1:0] = c.crit_mv;
    write_reg(CFG_CRIT_MV, word);
    write_reg(CFG_LOW_TIMEOUT, c.low_timeout);
    write_reg(CFG_CRIT_TIMEOUT, c.crit_timeout);
    write_reg(CFG_INACT_TIMEOUT, c.inact_timeout);
    cfg_valid_i <= 1'b0;
    limits = c;
  endtask

  task automatic check_field(input string field, input int unsigned want_v,
                             input int unsigned got_v);
    if (want_v != got_v) begin
      $display("%0t: %s expected %0d, got %0d", $time, field, want_v, got_v);
      mismatches++;
    end
  endtask

  task automatic test_directed_cases();
    gaps_on = 1'b1;
    feed_reading('{13'd0,    1'b0, 1'b0, 32'd0, 32'd0});
    feed_reading('{13'd8191, 1'b1, 1'b0, 32'd1, 32'hFFFF_FFFF});
    feed_reading('{13'd3000, 1'b1, 1'b1, 32'd2, 32'd0});
    feed_reading('{13'd2999, 1'b0, 1'b1, 32'd3, 32'd0});
    feed_reading('{13'd3001, 1'b0, 1'b0, 32'd4, 32'd300000});
    feed_reading('{13'd3780, 1'b0, 1'b0, 32'd5, 32'd300001});
    feed_reading('{13'd3781, 1'b1, 1'b0, 32'd6, 32'd0});
    feed_reading('{13'd4100, 1'b1, 1'b1, 32'd7, 32'd0});
    feed_reading('{13'd4101, 1'b0, 1'b0, 32'd8, 32'd0});
    feed_reading('{13'd6000, 1'b0, 1'b0, 32'd9, 32'd0});
    feed_reading('{13'd3100, 1'b0, 1'b0, 32'd5009, 32'd0});
    feed_reading('{13'd3100, 1'b0, 1'b0, 32'd5010, 32'd0});
    feed_reading('{13'd2900, 1'b0, 1'b0, 32'd10010, 32'd0});
    feed_reading('{13'd2900, 1'b0, 1'b1, 32'd10011, 32'hFFFF_FFFF});
    feed_reading('{13'd4000, 1'b0, 1'b0, 32'hFFFF_FF00, 32'd0});
    feed_reading('{13'd3100, 1'b0, 1'b0, 32'h0000_1000, 32'd0});
    feed_reading('{13'd3100, 1'b0, 1'b0, 32'd4901, 32'd0});
    feed_reading('{13'd3200, 1'b0, 1'b0, 32'd4902, 32'd0});
    feed_reading('{13'd3201, 1'b0, 1'b0, 32'd4903, 32'd0});
    feed_reading('{13'h0AAA, 1'b0, 1'b0, 32'h5555_5555, 32'hAAAA_AAAA});
    feed_reading('{13'h1555, 1'b1, 1'b1, 32'hAAAA_AAAA, 32'h5555_5555});
    feed_reading('{13'd8191, 1'b1, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
  endtask

  task automatic test_limit_extremes();
    cfg_t corner [4];
    corner[0] = '{13'd0,    13'd0,    32'd0,          32'd0,          32'd0};
    corner[1] = '{13'd8191, 13'd8191, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
    corner[2] = '{13'd0,    13'd8191, 32'hFFFF_FFFF, 32'd0,          32'd0};
    corner[3] = '{13'd8191, 13'd0,    32'd0,          32'hFFFF_FFFF, 32'hFFFF_FFFF};
    for (int k = 0; k < 4; k++) begin
      settle_reports();
      program_limits(corner[k]);
      gaps_on = (k % 2 == 0);
      repeat (15) feed_reading(next_reading());
    end
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < 8; p++) begin
      settle_reports();
      program_limits(random_limits());
      gaps_on = ($urandom_range(0, 3) != 0);
      repeat (40) feed_reading(next_reading());
    end
  endtask

  task automatic test_output_backpressure();
    settle_reports();
    gaps_on = 1'b0;
    hold_len = 150;
    repeat (24) feed_reading(next_reading());
    settle_reports();
    gaps_on = 1'b1;
  endtask

  always @(posedge clk_i) begin
    if (hold_len != 0) begin
      hold_left = hold_len;
      hold_len = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      if (ready_pos == 0) begin
        case ($urandom_range(0, 3))
          0: ready_mask = '1;
          1: ready_mask = 16'($urandom);
          2: ready_mask = 16'($urandom | $urandom);
          default: ready_mask = 16'($urandom & $urandom);
        endcase
      end
      out_ready_i <= ready_mask[ready_pos];
      ready_pos = ready_pos + 1'b1;
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected word, expected none, got power_state %0d",
                 $time, power_state_o);
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        check_field("level_percent", want.level_percent, level_percent_o);
        check_field("charge_step", want.charge_step, charge_step_o);
        check_field("min_mv", want.min_mv, min_mv_o);
        check_field("max_mv", want.max_mv, max_mv_o);
        check_field("power_state", want.power_state, power_state_o);
        check_field("state_changed", want.state_changed, state_changed_o);
        check_field("can_fly", want.can_fly, can_fly_o);
        check_field("charging_led_start", want.charging_led_start, charging_led_start_o);
        check_field("lowbat_led_start", want.lowbat_led_start, lowbat_led_start_o);
        check_field("shutdown_request", want.shutdown_request, shutdown_request_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_cases();
    test_limit_extremes();
    test_random_phases();
    test_output_backpressure();
    settle_reports();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
